/* hdl/pfc_pkg.sv */
// ----------------------------------------------------------------------------
// pfc_pkg
// Shared types, letter codes and 5x5 square helpers for the digraph cipher.
// ----------------------------------------------------------------------------
package pfc_pkg;

    typedef logic [4:0] letter_t;
    typedef logic [4:0] cell_t;
    typedef logic [2:0] coord_t;

    localparam letter_t LETTER_I   = 5'd8;
    localparam letter_t LETTER_J   = 5'd9;
    localparam letter_t LETTER_X   = 5'd23;
    localparam letter_t LETTER_Z   = 5'd25;
    localparam letter_t LETTER_MAX = 5'd25;
    localparam cell_t   SQ_CELLS   = 5'd25;
    localparam coord_t  SQ_LAST    = 3'd4;

    typedef enum logic [1:0] {
        OP_KEY_LETTER  = 2'd0,
        OP_KEY_END     = 2'd1,
        OP_TEXT_LETTER = 2'd2,
        OP_TEXT_END    = 2'd3
    } opcode_t;

    // own cell and partner cell of one pair letter
    typedef struct packed {
        cell_t own;
        cell_t other;
    } pos_pair_t;

    function automatic letter_t fold_j(input letter_t ch);
        return (ch == LETTER_J) ? LETTER_I : ch;
    endfunction

    function automatic coord_t pos_row(input cell_t p);
        coord_t r;
        if (p >= 5'd20) begin
            r = 3'd4;
        end else if (p >= 5'd15) begin
            r = 3'd3;
        end else if (p >= 5'd10) begin
            r = 3'd2;
        end else if (p >= 5'd5) begin
            r = 3'd1;
        end else begin
            r = 3'd0;
        end
        return r;
    endfunction

    function automatic coord_t pos_col(input cell_t p);
        cell_t base;
        cell_t diff;
        base = {pos_row(p), 2'b00} + {2'b00, pos_row(p)};
        diff = p - base;
        return diff[2:0];
    endfunction

    function automatic coord_t inc5(input coord_t x);
        return (x == SQ_LAST) ? 3'd0 : x + 3'd1;
    endfunction

    function automatic coord_t dec5(input coord_t x);
        return (x == 3'd0) ? SQ_LAST : x - 3'd1;
    endfunction

endpackage

/* hdl/pfc_cell_unit.sv */
// ----------------------------------------------------------------------------
// pfc_cell_unit
// Shared cell-address unit: maps one pair letter's cell to its output cell.
// ----------------------------------------------------------------------------
module pfc_cell_unit (
    input  pfc_pkg::pos_pair_t pos_in,
    input  logic               decrypt,
    output pfc_pkg::cell_t     cell_addr
);
    import pfc_pkg::*;

    coord_t r_own, c_own, r_oth, c_oth;
    coord_t r_out, c_out;

    always_comb begin
        r_own = pos_row(pos_in.own);
        c_own = pos_col(pos_in.own);
        r_oth = pos_row(pos_in.other);
        c_oth = pos_col(pos_in.other);
        if (r_own == r_oth) begin
            r_out = r_own;
            c_out = decrypt ? dec5(c_own) : inc5(c_own);
        end else if (c_own == c_oth) begin
            r_out = decrypt ? dec5(r_own) : inc5(r_own);
            c_out = c_own;
        end else begin
            // rectangle: own row, partner column
            r_out = r_own;
            c_out = c_oth;
        end
    end

    assign cell_addr = {r_out, 2'b00} + {2'b00, r_out} + {2'b00, c_out};

endmodule

/* hdl/playfair_digraph_cipher.sv */
// A key letter or an unpaired text letter leaves s_tready high. A key end
// runs the fill sweep (one alphabet letter checked per cycle). A letter or
// text end that completes a pair holds off the next transfer until S_EMIT2,
// set by the single read port of the position and square tables and the one
// cell-address unit; the two results follow as the output drains.
// Reset (aresetn low, synchronous) clears mode, square build state and hold.
// ----------------------------------------------------------------------------
// playfair_digraph_cipher
// Builds a 5x5 key square from key letters and ciphers text letter pairs.
// ----------------------------------------------------------------------------
module playfair_digraph_cipher (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic       cfg_wdata,     // cipher_mode
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,       // [4:0] letter
    input  logic [1:0] s_tuser,       // [1:0] opcode
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,       // [4:0] out_letter
    output logic       m_tlast        // pair_last
);
    import pfc_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_FILL  = 9'b000000010,
        S_POS1  = 9'b000000100,
        S_POS2  = 9'b000001000,
        S_CALC1 = 9'b000010000,
        S_CALC2 = 9'b000100000,
        S_CELL  = 9'b001000000,
        S_EMIT1 = 9'b010000000,
        S_EMIT2 = 9'b100000000
    } state_t;

    state_t  state_reg, state_next;
    logic    mode_reg;
    logic    key_phase_reg, key_phase_next;
    cell_t   fill_index_reg, fill_index_next;
    letter_t fill_ch_reg, fill_ch_next;
    letter_t held_reg, held_next;
    logic    held_valid_reg, held_valid_next;
    letter_t first_reg, first_next;
    letter_t second_reg, second_next;
    logic    used_reg [26];

    letter_t square_mem [25];
    cell_t   pos_mem [26];
    cell_t   pos_rd_reg;
    letter_t sq_rd_reg;
    letter_t pos_raddr;
    cell_t   sq_raddr;

    cell_t   p1_reg, p2_reg;
    letter_t o1_reg, o2_reg;

    logic    m_tvalid_reg, m_tvalid_next;
    letter_t m_letter_reg, m_letter_next;
    logic    m_tlast_reg, m_tlast_next;
    logic    out_free;

    pos_pair_t unit_in;
    cell_t     unit_addr;

    logic    xfer_in;
    letter_t in_letter;
    logic    in_ok;
    logic    place_req;
    letter_t place_ch;
    logic    place_en;

    pfc_cell_unit u_cell (
        .pos_in    (unit_in),
        .decrypt   (mode_reg),
        .cell_addr (unit_addr)
    );

    assign s_tready  = (state_reg == S_IDLE);
    assign xfer_in   = s_tvalid && s_tready;
    assign in_letter = s_tdata[4:0];
    assign in_ok     = (in_letter <= LETTER_MAX);
    assign out_free  = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {3'b000, m_letter_reg};
    assign m_tlast  = m_tlast_reg;

    // one letter placement per cycle, from a key letter or the fill sweep
    always_comb begin
        place_ch = (state_reg == S_FILL) ? fill_ch_reg : fold_j(in_letter);
        place_en = place_req && !used_reg[place_ch] && (fill_index_reg < SQ_CELLS);
    end

    always_comb begin
        pos_raddr = (state_reg == S_POS2) ? second_reg : first_reg;
        if (state_reg == S_CALC2) begin
            unit_in.own   = p2_reg;
            unit_in.other = p1_reg;
        end else begin
            unit_in.own   = p1_reg;
            unit_in.other = pos_rd_reg;
        end
        sq_raddr = unit_addr;
    end

    always_comb begin
        state_next      = state_reg;
        key_phase_next  = key_phase_reg;
        fill_index_next = fill_index_reg;
        fill_ch_next    = fill_ch_reg;
        held_next       = held_reg;
        held_valid_next = held_valid_reg;
        first_next      = first_reg;
        second_next     = second_reg;
        place_req       = 1'b0;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_letter_next   = m_letter_reg;
        m_tlast_next    = m_tlast_reg;

        case (state_reg)
            S_IDLE: begin
                if (xfer_in) begin
                    case (opcode_t'(s_tuser))
                        OP_KEY_LETTER: begin
                            place_req = !key_phase_reg && in_ok;
                        end
                        OP_KEY_END: begin
                            if (!key_phase_reg) begin
                                fill_ch_next = '0;
                                state_next   = S_FILL;
                            end
                        end
                        OP_TEXT_LETTER: begin
                            if (key_phase_reg && in_ok) begin
                                if (!held_valid_reg) begin
                                    held_next       = in_letter;
                                    held_valid_next = 1'b1;
                                end else if (!mode_reg && held_reg == in_letter) begin
                                    // doubled letter: pad with X, carry the second
                                    first_next  = fold_j(held_reg);
                                    second_next = LETTER_X;
                                    state_next  = S_POS1;
                                end else begin
                                    first_next      = fold_j(held_reg);
                                    second_next     = fold_j(in_letter);
                                    held_valid_next = 1'b0;
                                    state_next      = S_POS1;
                                end
                            end
                        end
                        OP_TEXT_END: begin
                            if (key_phase_reg && held_valid_reg) begin
                                first_next      = fold_j(held_reg);
                                second_next     = LETTER_Z;
                                held_valid_next = 1'b0;
                                state_next      = S_POS1;
                            end
                        end
                        default: begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_FILL: begin
                place_req = (fill_ch_reg != LETTER_J);
                if (fill_ch_reg == LETTER_MAX) begin
                    key_phase_next = 1'b1;
                    state_next     = S_IDLE;
                end else begin
                    fill_ch_next = fill_ch_reg + 5'd1;
                end
            end
            S_POS1:  state_next = S_POS2;
            S_POS2:  state_next = S_CALC1;
            S_CALC1: state_next = S_CALC2;
            S_CALC2: state_next = S_CELL;
            S_CELL:  state_next = S_EMIT1;
            S_EMIT1: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_letter_next = o1_reg;
                    m_tlast_next  = 1'b0;
                    state_next    = S_EMIT2;
                end
            end
            S_EMIT2: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_letter_next = o2_reg;
                    m_tlast_next  = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (place_en) begin
            fill_index_next = fill_index_reg + 5'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            mode_reg       <= 1'b0;
            key_phase_reg  <= 1'b0;
            fill_index_reg <= '0;
            fill_ch_reg    <= '0;
            held_reg       <= '0;
            held_valid_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
            for (int i = 0; i < 26; i++) begin
                used_reg[i] <= 1'b0;
            end
        end else begin
            state_reg      <= state_next;
            key_phase_reg  <= key_phase_next;
            fill_index_reg <= fill_index_next;
            fill_ch_reg    <= fill_ch_next;
            held_reg       <= held_next;
            held_valid_reg <= held_valid_next;
            m_tvalid_reg   <= m_tvalid_next;
            if (cfg_we) begin
                mode_reg <= cfg_wdata;
            end
            if (place_en) begin
                used_reg[place_ch] <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        first_reg    <= first_next;
        second_reg   <= second_next;
        m_letter_reg <= m_letter_next;
        m_tlast_reg  <= m_tlast_next;
        if (state_reg == S_POS2) begin
            p1_reg <= pos_rd_reg;
        end
        if (state_reg == S_CALC1) begin
            p2_reg <= pos_rd_reg;
        end
        if (state_reg == S_CALC2) begin
            o1_reg <= sq_rd_reg;
        end
        if (state_reg == S_CELL) begin
            o2_reg <= sq_rd_reg;
        end
    end

    // key square and letter position tables
    always_ff @(posedge aclk) begin
        if (place_en) begin
            square_mem[fill_index_reg] <= place_ch;
            pos_mem[place_ch]          <= fill_index_reg;
        end
        pos_rd_reg <= pos_mem[pos_raddr];
        sq_rd_reg  <= square_mem[sq_raddr];
    end

`ifndef SYNTHESIS
    a_key_phase_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !$fell(key_phase_reg))
        else $error("key square unlocked without reset");

    a_square_full: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(key_phase_reg) |-> fill_index_reg == SQ_CELLS)
        else $error("key square locked with empty cells");

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_index_reg <= SQ_CELLS)
        else $error("fill index past last cell");

    a_pair_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EMIT2 && out_free) |=> m_tvalid_reg && m_tlast_reg)
        else $error("second pair letter not presented");
`endif

endmodule

/* dv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the Playfair digraph cipher. It builds one key
// square, then streams text through phases that alternate between encrypt
// and decrypt. A scoreboard class predicts every output letter and checks
// the results in order. Both stream sides stall at random, and one long
// output hold-off backs the block up into its input.
// ----------------------------------------------------------------------------
module testbench;
    import pfc_pkg::*;

    localparam int SIDE          = 5;
    localparam int SETTLE_CYCLES = 40;
    localparam int PHASE_ITEMS   = 240;
    localparam int HOLD_CYCLES   = 400;

    typedef struct packed {
        letter_t letter;
        logic    last;
    } cipher_out_t;

    class cipher_scoreboard;
        letter_t     square [SIDE*SIDE];
        int          cell_of [LETTER_MAX+1];
        bit          placed [LETTER_MAX+1];
        int          fill_count;
        bit          locked;
        letter_t     held;
        bit          held_ok;
        bit          decrypt;
        cipher_out_t expected_q [$];
        int          errors;
        int          n_inputs;
        int          n_checked;

        function new();
            fill_count = 0;
            locked     = 0;
            held       = '0;
            held_ok    = 0;
            decrypt    = 0;
            errors     = 0;
            n_inputs   = 0;
            n_checked  = 0;
            foreach (placed[i]) placed[i] = 0;
        endfunction

        function void place_letter(letter_t ch);
            if (placed[ch] || fill_count >= SIDE*SIDE) return;
            square[fill_count] = ch;
            cell_of[ch] = fill_count;
            placed[ch] = 1;
            fill_count++;
        endfunction

        // two output letters of one digraph, J looked up as I
        function void cipher_pair(letter_t a, letter_t b);
            int p1, p2, r1, c1, r2, c2, shift;
            letter_t o1, o2;
            p1 = cell_of[(a == LETTER_J) ? LETTER_I : a];
            p2 = cell_of[(b == LETTER_J) ? LETTER_I : b];
            r1 = p1 / SIDE;
            c1 = p1 % SIDE;
            r2 = p2 / SIDE;
            c2 = p2 % SIDE;
            shift = decrypt ? SIDE - 1 : 1;
            if (r1 == r2) begin
                o1 = square[r1*SIDE + (c1 + shift) % SIDE];
                o2 = square[r2*SIDE + (c2 + shift) % SIDE];
            end else if (c1 == c2) begin
                o1 = square[((r1 + shift) % SIDE)*SIDE + c1];
                o2 = square[((r2 + shift) % SIDE)*SIDE + c2];
            end else begin
                o1 = square[r1*SIDE + c2];
                o2 = square[r2*SIDE + c1];
            end
            expected_q.push_back(cipher_out_t'{o1, 1'b0});
            expected_q.push_back(cipher_out_t'{o2, 1'b1});
        endfunction

        function void note_input(opcode_t op, letter_t ch);
            n_inputs++;
            case (op)
                OP_KEY_LETTER: begin
                    if (!locked && ch <= LETTER_MAX)
                        place_letter((ch == LETTER_J) ? LETTER_I : ch);
                end
                OP_KEY_END: begin
                    if (!locked) begin
                        for (int c = 0; c <= LETTER_MAX; c++)
                            if (letter_t'(c) != LETTER_J) place_letter(letter_t'(c));
                        locked = 1;
                    end
                end
                OP_TEXT_LETTER: begin
                    if (locked && ch <= LETTER_MAX) begin
                        if (!held_ok) begin
                            held = ch;
                            held_ok = 1;
                        end else if (!decrypt && held == ch) begin
                            // doubled letter: filler goes in, second copy stays held
                            cipher_pair(held, LETTER_X);
                        end else begin
                            cipher_pair(held, ch);
                            held_ok = 0;
                        end
                    end
                end
                default: begin
                    if (locked && held_ok) begin
                        cipher_pair(held, LETTER_Z);
                        held_ok = 0;
                    end
                end
            endcase
        endfunction

        function void check_result(letter_t got, logic got_last);
            cipher_out_t want;
            n_checked++;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result letter %0d last %0b, expected none",
                         $time, got, got_last);
                return;
            end
            want = expected_q.pop_front();
            if (got !== want.letter) begin
                errors++;
                $display("%0t: out_letter mismatch, expected %0d, got %0d",
                         $time, want.letter, got);
            end
            if (got_last !== want.last) begin
                errors++;
                $display("%0t: pair_last mismatch, expected %0b, got %0b",
                         $time, want.last, got_last);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic       aclk      = 1'b0;
    logic       aresetn   = 1'b0;
    logic       cfg_we    = 1'b0;
    logic       cfg_wdata = 1'b0;
    logic       s_tvalid  = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata   = 8'd0;   // [4:0] letter
    logic [1:0] s_tuser   = OP_KEY_LETTER;   // [1:0] opcode
    logic       m_tvalid;
    logic       m_tready  = 1'b0;
    logic [7:0] m_tdata;            // [4:0] out_letter
    logic       m_tlast;            // pair_last

    cipher_scoreboard sb;
    bit tx_steady   = 0;
    int results_seen = 0;
    int hold_left   = 0;
    bit hold_done   = 0;

    playfair_digraph_cipher i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always #1 aclk = ~aclk;

    // output side: random stalls, one long hold-off, one stretch always ready
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!hold_done && results_seen >= 60) begin
            m_tready  <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1;
        end else if (results_seen >= 400 && results_seen < 550) begin
            m_tready <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(99) >= 28);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_result(m_tdata[4:0], m_tlast);
            results_seen <= results_seen + 1;
        end
    end

    task automatic send_item(opcode_t op, letter_t ch);
        while (!tx_steady && $urandom_range(99) < 28) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {3'b000, ch};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_input(op, ch);
    endtask

    // stop offering, wait for every predicted letter, then let a key fill finish
    task automatic settle();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_mode(logic decrypt_on);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= decrypt_on;
        @(posedge aclk);
        cfg_we <= 1'b0;
        sb.decrypt = decrypt_on;
    endtask

    initial begin
        letter_t prev;
        letter_t ch;
        int      r;
        int      n_done;
        sb = new();
        prev = '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // text before the square is locked is dropped
        send_item(OP_TEXT_LETTER, 5'd5);
        send_item(OP_TEXT_END, 5'd0);
        // key with J folding, repeats and out-of-range letters
        send_item(OP_KEY_LETTER, LETTER_J);
        send_item(OP_KEY_LETTER, LETTER_Z);
        send_item(OP_KEY_LETTER, 5'd0);
        send_item(OP_KEY_LETTER, LETTER_J);
        send_item(OP_KEY_LETTER, 5'd31);
        send_item(OP_KEY_LETTER, 5'd26);
        send_item(OP_KEY_LETTER, 5'd16);
        send_item(OP_KEY_LETTER, 5'd16);
        send_item(OP_KEY_LETTER, 5'd4);
        send_item(OP_KEY_END, 5'd0);
        // key commands after lock are dropped
        send_item(OP_KEY_LETTER, 5'd1);
        send_item(OP_KEY_END, 5'd31);
        // square is I Z A Q E / B C D F G / H K L M N / O P R S T / U V W X Y
        send_item(OP_TEXT_LETTER, 5'd11);
        send_item(OP_TEXT_LETTER, 5'd11);   // doubled letter gets X filler
        send_item(OP_TEXT_END, 5'd0);       // held letter padded with Z
        send_item(OP_TEXT_LETTER, 5'd31);
        send_item(OP_TEXT_LETTER, LETTER_J);
        send_item(OP_TEXT_LETTER, LETTER_I);
        send_item(OP_TEXT_LETTER, 5'd1);    // same row
        send_item(OP_TEXT_LETTER, 5'd3);
        send_item(OP_TEXT_LETTER, 5'd2);    // same column
        send_item(OP_TEXT_LETTER, 5'd15);
        send_item(OP_TEXT_LETTER, 5'd0);    // rectangle
        send_item(OP_TEXT_LETTER, 5'd19);
        send_item(OP_TEXT_END, 5'd0);       // nothing held

        for (int phase = 0; phase < 4; phase++) begin
            write_mode(phase % 2 == 0);
            tx_steady = (phase == 2);
            n_done = 0;
            while (n_done < PHASE_ITEMS) begin
                r = $urandom_range(99);
                if (r < 78) begin
                    if (r < 16) begin
                        ch = prev;
                    end else if (r < 26) begin
                        case ($urandom_range(3))
                            0: ch = LETTER_I;
                            1: ch = LETTER_J;
                            2: ch = LETTER_X;
                            default: ch = LETTER_Z;
                        endcase
                    end else begin
                        ch = letter_t'($urandom_range(LETTER_MAX));
                    end
                    send_item(OP_TEXT_LETTER, ch);
                    prev = ch;
                    n_done++;
                end else if (r < 90) begin
                    send_item(OP_TEXT_END, letter_t'($urandom_range(31)));
                    n_done++;
                end else if (r < 95) begin
                    send_item(OP_TEXT_LETTER, letter_t'($urandom_range(31, 26)));
                end else begin
                    send_item($urandom_range(1) ? OP_KEY_END : OP_KEY_LETTER,
                              letter_t'($urandom_range(31)));
                end
            end
        end
        settle();

        $display("run covered %0d input transfers on one key square in both modes,",
                 sb.n_inputs);
        $display("with %0d result transfers checked and %0d mismatches",
                 sb.n_checked, sb.errors);
        if (sb.errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("FAILURE");
        $finish;
    end

endmodule

/* playfair_digraph_cipher.f */
hdl/pfc_pkg.sv
hdl/pfc_cell_unit.sv
hdl/playfair_digraph_cipher.sv
dv/testbench.sv
